@@ design/servo_ack_frame_checker_top_macros.svh @@
// Assertion macros shared by the servo acknowledgement frame checker.
`ifndef SERVO_ACK_FRAME_CHECKER_TOP_MACROS_SVH
`define SERVO_ACK_FRAME_CHECKER_TOP_MACROS_SVH

// Condition must never hold at a clock edge outside reset.
`define SAF_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error(msg);

// Antecedent implies consequent in the same cycle.
`define SAF_ASSERT_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

@@ design/saf_pkg.sv @@
// Types and constants of the servo acknowledgement frame checker.
`default_nettype none

package saf_pkg;

  localparam int unsigned HeaderBytes = 7;
  localparam logic [7:0] SyncByte    = 8'hFF;
  localparam logic [7:0] AckCmdBit   = 8'h40;
  localparam logic [7:0] ChecksumMask = 8'hFE;

  localparam logic [1:0] OP_START   = 2'd0;
  localparam logic [1:0] OP_BYTE    = 2'd1;
  localparam logic [1:0] OP_TIMEOUT = 2'd2;

  localparam logic [3:0] ERR_OK          = 4'd0;
  localparam logic [3:0] ERR_HDR_TIMEOUT = 4'd1;
  localparam logic [3:0] ERR_SYNC0       = 4'd2;
  localparam logic [3:0] ERR_SYNC1       = 4'd3;
  localparam logic [3:0] ERR_ID          = 4'd4;
  localparam logic [3:0] ERR_CMD         = 4'd5;
  localparam logic [3:0] ERR_SIZE        = 4'd6;
  localparam logic [3:0] ERR_PAY_TIMEOUT = 4'd7;
  localparam logic [3:0] ERR_CHECKSUM    = 4'd8;
  localparam logic [3:0] ERR_INV_CHECKSUM = 4'd9;

  typedef struct packed {
    logic [1:0] opcode;
    logic [7:0] command_code;
    logic [7:0] payload_length;
    logic [7:0] rx_byte;
  } item_t;

  typedef struct packed {
    logic       payload_valid;
    logic [7:0] payload_index;
    logic [7:0] payload_byte;
    logic       done_res;
    logic [3:0] error_code;
  } result_t;

endpackage

`default_nettype wire

@@ design/servo_ack_frame_checker_top.sv @@
// Top level of the servo acknowledgement frame checker.
//
// Channel   Dir  Contents
// s_axis    in   tuser: opcode; tdata: command_code, payload_length, rx_byte
// m_axis    out  tuser: payload_valid, done_res; tdata: payload_index, payload_byte,
//                error_code
// cfg       in   device_id write
//
// One word per cycle is taken unless the output stalls; a word's result reaches the output register
// after it is accepted (input register, then the check logic into the output register).
// Reset clears the frame state and device_id; the checker starts idle.
// A word with a result waits in the input register while the output is stalled,
// and the input stalls in turn only when that register is full and cannot move.
`default_nettype none
`include "servo_ack_frame_checker_top_macros.svh"

module servo_ack_frame_checker_top (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         s_axis_tvalid,
  output logic        s_axis_tready,
  input  wire  [23:0] s_axis_tdata,   // command_code, payload_length, rx_byte
  input  wire  [1:0]  s_axis_tuser,   // opcode
  output logic        m_axis_tvalid,
  input  wire         m_axis_tready,
  output logic [23:0] m_axis_tdata,   // payload_index, payload_byte, error_code, zero pad
  output logic [1:0]  m_axis_tuser,   // payload_valid, done_res
  input  wire         cfg_we_i,
  input  wire  [7:0]  cfg_wdata_i
);

  saf_pkg::item_t   in_item;
  saf_pkg::item_t   core_item;
  saf_pkg::result_t core_res;
  saf_pkg::result_t out_q;
  logic             core_item_valid;
  logic             core_take;
  logic             core_res_valid;
  logic             out_valid_q;
  logic             out_space;

  assign in_item.opcode         = s_axis_tuser;
  assign in_item.command_code   = s_axis_tdata[7:0];
  assign in_item.payload_length = s_axis_tdata[15:8];
  assign in_item.rx_byte        = s_axis_tdata[23:16];

  saf_inreg u_inreg (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .in_item_i    (in_item),
    .item_valid_o (core_item_valid),
    .item_o       (core_item),
    .item_take_i  (core_take)
  );

  assign out_space = !out_valid_q || m_axis_tready;

  saf_core u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .item_valid_i (core_item_valid),
    .item_i       (core_item),
    .item_take_o  (core_take),
    .out_space_i  (out_space),
    .res_valid_o  (core_res_valid),
    .res_o        (core_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_space) begin
      out_valid_q <= core_take && core_res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_space && core_take && core_res_valid) begin
      out_q <= core_res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {4'd0, out_q.error_code, out_q.payload_byte, out_q.payload_index};
  assign m_axis_tuser  = {out_q.done_res, out_q.payload_valid};

  `SAF_ASSERT_NEVER(a_result_not_empty,
    out_valid_q && !out_q.payload_valid && !out_q.done_res,
    "result word carries neither payload nor done")

  `SAF_ASSERT_IMPLY(a_code_needs_done,
    out_valid_q && (out_q.error_code != saf_pkg::ERR_OK), out_q.done_res,
    "error code set without done")

  `SAF_ASSERT_NEVER(a_header_err_no_payload,
    out_valid_q && out_q.payload_valid &&
    (out_q.error_code == saf_pkg::ERR_HDR_TIMEOUT ||
     out_q.error_code == saf_pkg::ERR_PAY_TIMEOUT ||
     out_q.error_code == saf_pkg::ERR_SYNC0 || out_q.error_code == saf_pkg::ERR_SYNC1 ||
     out_q.error_code == saf_pkg::ERR_ID || out_q.error_code == saf_pkg::ERR_CMD ||
     out_q.error_code == saf_pkg::ERR_SIZE),
    "header or timeout error reported together with a payload byte")

endmodule

`default_nettype wire

@@ design/saf_inreg.sv @@
// Input register that holds one accepted word until the checker core takes it.
`default_nettype none

module saf_inreg (
  input  wire            clk_i,
  input  wire            rst_ni,
  input  wire            in_valid_i,
  output logic           in_ready_o,
  input  saf_pkg::item_t in_item_i,
  output logic           item_valid_o,
  output saf_pkg::item_t item_o,
  input  wire            item_take_i
);

  logic           valid_q;
  logic           valid_d;
  saf_pkg::item_t item_q;

  assign in_ready_o = !valid_q || item_take_i;
  assign valid_d    = in_valid_i ? 1'b1 : (valid_q && !item_take_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      item_q <= in_item_i;
    end
  end

  assign item_valid_o = valid_q;
  assign item_o       = item_q;

endmodule

`default_nettype wire

@@ design/saf_core.sv @@
// Frame state and the per-word header, payload and checksum checks.
`default_nettype none

module saf_core (
  input  wire              clk_i,
  input  wire              rst_ni,
  input  wire              cfg_we_i,
  input  wire [7:0]        cfg_wdata_i,
  input  wire              item_valid_i,
  input  saf_pkg::item_t   item_i,
  output logic             item_take_o,
  input  wire              out_space_i,
  output logic             res_valid_o,
  output saf_pkg::result_t res_o
);

  localparam logic [1:0] PH_IDLE    = 2'd0;
  localparam logic [1:0] PH_HEADER  = 2'd1;
  localparam logic [1:0] PH_PAYLOAD = 2'd2;
  localparam logic [7:0] LastHdrIdx = 8'(saf_pkg::HeaderBytes - 1);

  logic [1:0] phase_q, phase_d;
  logic [7:0] cnt_q, cnt_d;
  logic [7:0] exp_cmd_q, exp_cmd_d;
  logic [7:0] exp_len_q, exp_len_d;
  logic [7:0] csum_q, csum_d;
  logic [7:0] dev_id_q;
  logic [7:0] hdr_q [saf_pkg::HeaderBytes];
  logic       hdr_we;

  logic [7:0] frame_size;
  logic [7:0] cnt_inc;
  logic [7:0] seed_csum;
  logic [7:0] pay_csum;
  logic [3:0] hdr_code;

  function automatic logic [3:0] checksum_code(input logic [7:0] c, input logic [7:0] h5,
                                               input logic [7:0] h6);
    logic [3:0] code;
    code = saf_pkg::ERR_OK;
    if (h5 != (c & saf_pkg::ChecksumMask)) begin
      code = saf_pkg::ERR_CHECKSUM;
    end else if (h6 != (~c & saf_pkg::ChecksumMask)) begin
      code = saf_pkg::ERR_INV_CHECKSUM;
    end
    return code;
  endfunction

  assign frame_size = exp_len_q + 8'(saf_pkg::HeaderBytes);
  assign cnt_inc    = cnt_q + 8'd1;
  assign seed_csum  = frame_size ^ dev_id_q ^ exp_cmd_q;
  assign pay_csum   = csum_q ^ item_i.rx_byte;

  // Checks in priority order; the seventh byte is still on the input.
  always_comb begin
    hdr_code = saf_pkg::ERR_OK;
    if (hdr_q[0] != saf_pkg::SyncByte) begin
      hdr_code = saf_pkg::ERR_SYNC0;
    end else if (hdr_q[1] != saf_pkg::SyncByte) begin
      hdr_code = saf_pkg::ERR_SYNC1;
    end else if (hdr_q[3] != dev_id_q) begin
      hdr_code = saf_pkg::ERR_ID;
    end else if (hdr_q[4] != exp_cmd_q) begin
      hdr_code = saf_pkg::ERR_CMD;
    end else if (hdr_q[2] != frame_size) begin
      hdr_code = saf_pkg::ERR_SIZE;
    end
  end

  always_comb begin
    phase_d     = phase_q;
    cnt_d       = cnt_q;
    exp_cmd_d   = exp_cmd_q;
    exp_len_d   = exp_len_q;
    csum_d      = csum_q;
    hdr_we      = 1'b0;
    res_valid_o = 1'b0;
    res_o       = '0;
    case (item_i.opcode)
      saf_pkg::OP_START: begin
        exp_cmd_d = item_i.command_code | saf_pkg::AckCmdBit;
        exp_len_d = item_i.payload_length;
        cnt_d     = '0;
        csum_d    = '0;
        phase_d   = PH_HEADER;
      end
      saf_pkg::OP_TIMEOUT: begin
        if (phase_q != PH_IDLE) begin
          phase_d          = PH_IDLE;
          res_valid_o      = 1'b1;
          res_o.done_res   = 1'b1;
          res_o.error_code = (phase_q == PH_HEADER) ? saf_pkg::ERR_HDR_TIMEOUT
                                                    : saf_pkg::ERR_PAY_TIMEOUT;
        end
      end
      saf_pkg::OP_BYTE: begin
        if (phase_q == PH_HEADER) begin
          hdr_we = 1'b1;
          cnt_d  = cnt_inc;
          if (cnt_q == LastHdrIdx) begin
            if (hdr_code != saf_pkg::ERR_OK) begin
              phase_d          = PH_IDLE;
              res_valid_o      = 1'b1;
              res_o.done_res   = 1'b1;
              res_o.error_code = hdr_code;
            end else begin
              csum_d = seed_csum;
              cnt_d  = '0;
              if (exp_len_q == 8'd0) begin
                phase_d          = PH_IDLE;
                res_valid_o      = 1'b1;
                res_o.done_res   = 1'b1;
                res_o.error_code = checksum_code(seed_csum, hdr_q[5], item_i.rx_byte);
              end else begin
                phase_d = PH_PAYLOAD;
              end
            end
          end
        end else if (phase_q == PH_PAYLOAD) begin
          csum_d              = pay_csum;
          cnt_d               = cnt_inc;
          res_valid_o         = 1'b1;
          res_o.payload_valid = 1'b1;
          res_o.payload_index = cnt_q;
          res_o.payload_byte  = item_i.rx_byte;
          if (cnt_inc == exp_len_q) begin
            phase_d          = PH_IDLE;
            res_o.done_res   = 1'b1;
            res_o.error_code = checksum_code(pay_csum, hdr_q[5], hdr_q[6]);
          end
        end
      end
      default: begin
      end
    endcase
  end

  // A word that produces a result waits for room in the output register.
  assign item_take_o = item_valid_i && (!res_valid_o || out_space_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_IDLE;
      cnt_q     <= '0;
      exp_cmd_q <= '0;
      exp_len_q <= '0;
      csum_q    <= '0;
    end else if (item_take_o) begin
      phase_q   <= phase_d;
      cnt_q     <= cnt_d;
      exp_cmd_q <= exp_cmd_d;
      exp_len_q <= exp_len_d;
      csum_q    <= csum_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dev_id_q <= '0;
    end else if (cfg_we_i) begin
      dev_id_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (item_take_o && hdr_we) begin
      hdr_q[cnt_q[2:0]] <= item_i.rx_byte;
    end
  end

endmodule

`default_nettype wire
